/* sv/polygon_area_box_convexity_core_macros.svh */
// ----------------------------------------------------------------------------
// Polygon core assertion macros
// Shared assertion forms for the polygon core checkers.
// ----------------------------------------------------------------------------
`ifndef POLYGON_AREA_BOX_CONVEXITY_CORE_MACROS_SVH
`define POLYGON_AREA_BOX_CONVEXITY_CORE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define PABC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pabc assertion failed");

// next-cycle implication
`define PABC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pabc assertion failed");

`endif

/* sv/pabc_pkg.sv */
// ----------------------------------------------------------------------------
// Polygon core package
// Default widths shared by the interfaces and the core.
// ----------------------------------------------------------------------------
`default_nettype none

package pabc_pkg;

  // default coordinate width
  localparam int unsigned COORD_BITS_DEF = 16;

  // width of the wrapping shoelace accumulator
  localparam int unsigned ACC_BITS = 64;

endpackage

`default_nettype wire

/* sv/pabc_vtx_if.sv */
// ----------------------------------------------------------------------------
// Polygon vertex channel
// Valid/ready channel carrying one vertex and its last-vertex flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface pabc_vtx_if #(
  parameter int unsigned COORD_BITS = pabc_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_coord;
  logic signed [COORD_BITS-1:0] y_coord;
  logic                         last_vertex;

  modport source (output valid, output x_coord, output y_coord, output last_vertex,
                  input ready);
  modport sink   (input valid, input x_coord, input y_coord, input last_vertex,
                  output ready);
endinterface

`default_nettype wire

/* sv/pabc_res_if.sv */
// ----------------------------------------------------------------------------
// Polygon result channel
// Valid/ready channel carrying area, bounding box and convexity of a polygon.
// ----------------------------------------------------------------------------
`default_nettype none

interface pabc_res_if #(
  parameter int unsigned COORD_BITS = pabc_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [2*COORD_BITS:0]        twice_area;
  logic signed [COORD_BITS:0]   centre_x_doubled;
  logic signed [COORD_BITS:0]   centre_y_doubled;
  logic [COORD_BITS-1:0]        box_width;
  logic [COORD_BITS-1:0]        box_height;
  logic                         is_convex;

  modport source (output valid, output twice_area, output centre_x_doubled,
                  output centre_y_doubled, output box_width, output box_height,
                  output is_convex, input ready);
  modport sink   (input valid, input twice_area, input centre_x_doubled,
                  input centre_y_doubled, input box_width, input box_height,
                  input is_convex, output ready);
endinterface

`default_nettype wire

/* sv/polygon_area_box_convexity_core.sv */
// A last vertex is registered in stage 1, then loads a free result register.
// Throughput: one vertex per cycle unless a last vertex stalls in stage 1;
// set by the product register feeding the shoelace accumulator and turn flags.
// Reset: rst_ni low clears vertex count, accumulator, turn flags and both
// pipeline valids; the first vertex after reset starts a new polygon.
// ----------------------------------------------------------------------------
// Polygon shoelace area, bounding box and convexity core
// Stage 1 forms edge and turn products against the held neighbours, stage 2
// accumulates them and loads the result register on the last vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module polygon_area_box_convexity_core #(
  parameter int unsigned COORD_BITS = pabc_pkg::COORD_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pabc_vtx_if.sink   vtx_i,
  pabc_res_if.source res_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * COORD_BITS + 2;
  localparam int unsigned AW = pabc_pkg::ACC_BITS;

  // --------------------------------------------------------------------------
  // vertex history
  // --------------------------------------------------------------------------
  logic [1:0]           cnt_q, cnt_d;
  logic signed [CW-1:0] first_x_q, first_y_q, second_x_q, second_y_q;
  logic signed [CW-1:0] prev_x_q, prev_y_q, pp_x_q, pp_y_q;
  logic signed [CW-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
  logic signed [CW-1:0] min_x_d, max_x_d, min_y_d, max_y_d;

  logic signed [CW-1:0] cx, cy, fx, fy;
  logic                 last, vtx_xfer;
  logic                 has_prev, has_two;

  logic s1_valid_q, s1_adv;

  assign cx       = vtx_i.x_coord;
  assign cy       = vtx_i.y_coord;
  assign last     = vtx_i.last_vertex;
  assign vtx_xfer = vtx_i.valid && vtx_i.ready;
  assign has_prev = (cnt_q != 2'd0);
  assign has_two  = cnt_q[1];

  // the first vertex closes onto itself
  assign fx = has_prev ? first_x_q : cx;
  assign fy = has_prev ? first_y_q : cy;

  always_comb begin
    if (!has_prev) begin
      min_x_d = cx;
      max_x_d = cx;
      min_y_d = cy;
      max_y_d = cy;
    end else begin
      min_x_d = (cx < min_x_q) ? cx : min_x_q;
      max_x_d = (cx > max_x_q) ? cx : max_x_q;
      min_y_d = (cy < min_y_q) ? cy : min_y_q;
      max_y_d = (cy > max_y_q) ? cy : max_y_q;
    end
    cnt_d = (cnt_q == 2'd3) ? cnt_q : cnt_q + 2'd1;
    if (last) begin
      cnt_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (vtx_xfer) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vtx_xfer) begin
      min_x_q  <= min_x_d;
      max_x_q  <= max_x_d;
      min_y_q  <= min_y_d;
      max_y_q  <= max_y_d;
      pp_x_q   <= prev_x_q;
      pp_y_q   <= prev_y_q;
      prev_x_q <= cx;
      prev_y_q <= cy;
      if (!has_prev) begin
        first_x_q <= cx;
        first_y_q <= cy;
      end
      if (cnt_q == 2'd1) begin
        second_x_q <= cx;
        second_y_q <= cy;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: edge terms and turn products
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] e1_dx, e1_sy, e2_dx, e2_sy;
  logic signed [PW-1:0] e1_p, e2_p;
  logic signed [DW-1:0] t_ux [3];
  logic signed [DW-1:0] t_uy [3];
  logic signed [DW-1:0] t_vx [3];
  logic signed [DW-1:0] t_vy [3];
  logic signed [PW-1:0] t_m1 [3];
  logic signed [PW-1:0] t_m2 [3];
  logic [2:0]           t_en;

  always_comb begin
    e1_dx = DW'(prev_x_q) - DW'(cx);
    e1_sy = DW'(prev_y_q) + DW'(cy);
    e2_dx = DW'(cx) - DW'(fx);
    e2_sy = DW'(cy) + DW'(fy);
    e1_p  = has_prev ? PW'(e1_dx) * PW'(e1_sy) : '0;
    e2_p  = last ? PW'(e2_dx) * PW'(e2_sy) : '0;

    // turn a -> b -> c: u = b - a, v = c - a
    t_ux[0] = DW'(prev_x_q) - DW'(pp_x_q);
    t_uy[0] = DW'(prev_y_q) - DW'(pp_y_q);
    t_vx[0] = DW'(cx) - DW'(pp_x_q);
    t_vy[0] = DW'(cy) - DW'(pp_y_q);
    t_ux[1] = DW'(cx) - DW'(prev_x_q);
    t_uy[1] = DW'(cy) - DW'(prev_y_q);
    t_vx[1] = DW'(first_x_q) - DW'(prev_x_q);
    t_vy[1] = DW'(first_y_q) - DW'(prev_y_q);
    t_ux[2] = DW'(first_x_q) - DW'(cx);
    t_uy[2] = DW'(first_y_q) - DW'(cy);
    t_vx[2] = DW'(second_x_q) - DW'(cx);
    t_vy[2] = DW'(second_y_q) - DW'(cy);
    for (int i = 0; i < 3; i++) begin
      t_m1[i] = PW'(t_ux[i]) * PW'(t_vy[i]);
      t_m2[i] = PW'(t_uy[i]) * PW'(t_vx[i]);
    end
    t_en = {last && has_two, last && has_two, has_two};
  end

  logic                 s1_last_q, s1_conv_ok_q;
  logic signed [PW-1:0] s1_e1_q, s1_e2_q;
  logic signed [PW-1:0] s1_m1_q [3];
  logic signed [PW-1:0] s1_m2_q [3];
  logic [2:0]           s1_en_q;
  logic signed [CW-1:0] s1_min_x_q, s1_max_x_q, s1_min_y_q, s1_max_y_q;
  logic                 res_valid_q;

  // a last vertex in stage 1 waits for the result register to free up
  assign s1_adv      = s1_valid_q && (!s1_last_q || !res_valid_q || res_o.ready);
  assign vtx_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (vtx_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vtx_xfer) begin
      s1_last_q    <= last;
      s1_conv_ok_q <= has_two;
      s1_e1_q      <= e1_p;
      s1_e2_q      <= e2_p;
      s1_m1_q      <= t_m1;
      s1_m2_q      <= t_m2;
      s1_en_q      <= t_en;
      s1_min_x_q   <= min_x_d;
      s1_max_x_q   <= max_x_d;
      s1_min_y_q   <= min_y_d;
      s1_max_y_q   <= max_y_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: accumulate, close polygon, result register
  // --------------------------------------------------------------------------
  logic [AW-1:0] acc_q, acc_d, sum, mag;
  logic          cw_q, ccw_q, cw_d, ccw_d;
  logic          cw_all, ccw_all;

  always_comb begin
    sum     = acc_q + AW'(s1_e1_q) + AW'(s1_e2_q);
    cw_all  = cw_q;
    ccw_all = ccw_q;
    for (int i = 0; i < 3; i++) begin
      cw_all  = cw_all  | (s1_en_q[i] && (s1_m1_q[i] < s1_m2_q[i]));
      ccw_all = ccw_all | (s1_en_q[i] && (s1_m1_q[i] > s1_m2_q[i]));
    end
    mag = sum[AW-1] ? (~sum + AW'(1)) : sum;
    if (s1_last_q) begin
      acc_d = '0;
      cw_d  = 1'b0;
      ccw_d = 1'b0;
    end else begin
      acc_d = sum;
      cw_d  = cw_all;
      ccw_d = ccw_all;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cw_q        <= 1'b0;
      ccw_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        acc_q <= acc_d;
        cw_q  <= cw_d;
        ccw_q <= ccw_d;
      end
      if (s1_adv && s1_last_q) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  logic [2*CW:0]        area_q;
  logic signed [CW:0]   cen_x_q, cen_y_q;
  logic [CW-1:0]        wid_q, hgt_q;
  logic                 convex_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      area_q   <= mag[2*CW:0];
      cen_x_q  <= DW'(s1_min_x_q) + DW'(s1_max_x_q);
      cen_y_q  <= DW'(s1_min_y_q) + DW'(s1_max_y_q);
      wid_q    <= CW'(s1_max_x_q - s1_min_x_q);
      hgt_q    <= CW'(s1_max_y_q - s1_min_y_q);
      convex_q <= s1_conv_ok_q && (cw_all != ccw_all);
    end
  end

  assign res_o.valid            = res_valid_q;
  assign res_o.twice_area       = area_q;
  assign res_o.centre_x_doubled = cen_x_q;
  assign res_o.centre_y_doubled = cen_y_q;
  assign res_o.box_width        = wid_q;
  assign res_o.box_height       = hgt_q;
  assign res_o.is_convex        = convex_q;

endmodule

`default_nettype wire

/* sv/pabc_checker.sv */
// ----------------------------------------------------------------------------
// Polygon core port checker
// Watches the vertex and result handshakes of the core at its ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polygon_area_box_convexity_core_macros.svh"

module pabc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic vtx_valid_i,
  input wire logic vtx_ready_i,
  input wire logic vtx_last_i,
  input wire logic res_valid_i,
  input wire logic res_ready_i
);

  // a pending result is held until its transfer
  `PABC_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i)

  // vertices are only refused behind a stalled result
  `PABC_ASSERT_IMPL(a_ready_stall, !vtx_ready_i, res_valid_i && !res_ready_i)

  // a fresh result follows a last-vertex transfer
  `PABC_ASSERT_IMPL(a_res_origin, $rose(res_valid_i),
                    $past(vtx_valid_i && vtx_ready_i && vtx_last_i, 2))

endmodule

bind polygon_area_box_convexity_core pabc_checker u_pabc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .vtx_valid_i (vtx_i.valid),
  .vtx_ready_i (vtx_i.ready),
  .vtx_last_i  (vtx_i.last_vertex),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready)
);

`default_nettype wire
